FILE: rtl/lru_order_tracker_unit_defines.svh
// assertion macros for the lru order tracker
// expects clk and rst in the scope of each use
`ifndef LRU_ORDER_TRACKER_UNIT_DEFINES_SVH
`define LRU_ORDER_TRACKER_UNIT_DEFINES_SVH

// same-cycle implication, off during reset
`define LOT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define LOT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/lot_pkg.sv
// shared types and constants for the lru order tracker
// no dependencies; used by every module of the block
package lot_pkg;

  localparam int MAX_ENTRIES_DEF = 32;
  localparam int KEY_W           = 8;
  localparam int CAP_W           = 6;
  localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;
  localparam int FIFO_DEPTH      = 2;

  typedef enum logic {
    OP_ACCESS = 1'b0,
    OP_DUMP   = 1'b1
  } lot_op_e;

  typedef struct packed {
    logic             req_type;
    logic [KEY_W-1:0] key;
  } lot_in_t;

  typedef struct packed {
    logic [KEY_W-1:0] entry_key;
    logic             entry_valid;
    logic             last;
  } lot_out_t;

  typedef struct packed {
    lot_op_e          op;
    logic [KEY_W-1:0] key;
  } lot_cmd_t;

  // queue side of the front/back link
  typedef struct packed {
    logic full;
    logic empty;
  } lot_q_stat_t;

endpackage

FILE: rtl/lot_front.sv
// front stage: accepts request items, decodes the request type
// and pushes commands into the queue; uses lot_pkg
module lot_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  lot_pkg::lot_in_t     in_item,
  input  lot_pkg::lot_q_stat_t q_stat,
  output logic                 push,
  output lot_pkg::lot_cmd_t    push_cmd
);

  logic              stg_valid;
  lot_pkg::lot_cmd_t stg_cmd;
  lot_pkg::lot_op_e  op_dec;

  always_comb begin
    unique case (in_item.req_type)
      1'b1:    op_dec = lot_pkg::OP_DUMP;
      default: op_dec = lot_pkg::OP_ACCESS;
    endcase
  end

  assign push     = stg_valid && !q_stat.full;
  assign push_cmd = stg_cmd;
  assign in_ready = !stg_valid || !q_stat.full;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (in_ready) begin
      stg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stg_cmd.op  <= op_dec;
      stg_cmd.key <= in_item.key;
    end
  end

endmodule

FILE: rtl/lot_cmd_fifo.sv
// short command queue between the front and back stages
// uses lot_pkg for the command type and depth
module lot_cmd_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  lot_pkg::lot_cmd_t    push_cmd,
  input  logic                 pop,
  output lot_pkg::lot_cmd_t    head,
  output lot_pkg::lot_q_stat_t q_stat
);

  localparam int PTR_W = (lot_pkg::FIFO_DEPTH > 1) ? $clog2(lot_pkg::FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(lot_pkg::FIFO_DEPTH + 1);

  lot_pkg::lot_cmd_t       slots [lot_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0]        wr_ptr;
  logic [PTR_W-1:0]        rd_ptr;
  logic [CNT_W-1:0]        fill;

  assign q_stat.full  = (fill == CNT_W'(lot_pkg::FIFO_DEPTH));
  assign q_stat.empty = (fill == '0);
  assign head         = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(lot_pkg::FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(lot_pkg::FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

FILE: rtl/lot_back.sv
// back stage: recency list cells, parallel key match, shift update,
// dump sequencing and the output register; uses lot_pkg
module lot_back #(
  parameter int MAX_ENTRIES = lot_pkg::MAX_ENTRIES_DEF,
  parameter int CNT_W       = $clog2(MAX_ENTRIES + 1)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [lot_pkg::CAP_W-1:0] capacity,
  input  lot_pkg::lot_q_stat_t      q_stat,
  input  lot_pkg::lot_cmd_t         head,
  output logic                      pop,
  output logic [CNT_W-1:0]          count,
  output logic                      out_valid,
  input  logic                      out_ready,
  output lot_pkg::lot_out_t         out_item
);

  localparam int KW    = lot_pkg::KEY_W;
  localparam int CMP_W = (CNT_W > lot_pkg::CAP_W) ? CNT_W : lot_pkg::CAP_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SHIFT,
    S_DUMP
  } state_t;

  state_t                 state;
  logic [KW-1:0]          list      [MAX_ENTRIES];
  logic [KW-1:0]          list_next [MAX_ENTRIES];
  logic [KW-1:0]          nxt       [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] mvec;
  logic [MAX_ENTRIES-1:0] mvec_next;
  logic [MAX_ENTRIES-1:0] ge;
  logic [MAX_ENTRIES-1:0] take;
  logic [KW-1:0]          key;
  logic [KW-1:0]          wval;
  logic [CNT_W-1:0]       idx;
  logic                   shift_en;
  logic                   append;
  logic                   hit;
  logic                   out_free;
  logic                   dump_last;
  logic [CMP_W-1:0]       cap_x;
  logic [CMP_W-1:0]       cap_eff;

  assign cap_x   = CMP_W'(capacity);
  assign cap_eff = (capacity == '0) ? CMP_W'(1) :
                   (cap_x > CMP_W'(MAX_ENTRIES)) ? CMP_W'(MAX_ENTRIES) : cap_x;

  assign out_free  = !out_valid || out_ready;
  assign pop       = (state == S_IDLE) && !q_stat.empty;
  assign hit       = |mvec;
  assign dump_last = (idx == count - 1'b1);

  // neighbor tap of each cell, the top cell has none
  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_tap
    if (g < MAX_ENTRIES - 1) begin : g_mid
      assign nxt[g] = list[g + 1];
    end else begin : g_top
      assign nxt[g] = list[g];
    end
  end

  // parallel match against the live slots; keys are unique so at most one hits
  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      mvec_next[i] = (CNT_W'(i) < count) && (list[i] == head.key);
      ge[i]        = |(mvec & ~({MAX_ENTRIES{1'b1}} << (i + 1)));
    end
  end

  always_comb begin
    shift_en = 1'b0;
    append   = 1'b0;
    take     = '0;
    wval     = key;
    unique case (state)
      S_SHIFT: begin
        if (hit) begin
          shift_en = 1'b1;
          take     = ge;
        end else if (CMP_W'(count) < cap_eff) begin
          append = 1'b1;
        end else begin
          // evict the least recent key
          shift_en = 1'b1;
          take     = '1;
        end
      end
      S_DUMP: begin
        // rotate so the next key reaches slot zero
        if (out_free && count != '0) begin
          shift_en = 1'b1;
          take     = '1;
          wval     = list[0];
        end
      end
      default: begin
        shift_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      list_next[i] = list[i];
      if (shift_en) begin
        if (take[i] && (CNT_W'(i + 1) < count)) begin
          list_next[i] = nxt[i];
        end else if (CNT_W'(i) == count - 1'b1) begin
          list_next[i] = wval;
        end
      end
      if (append && CNT_W'(i) == count) begin
        list_next[i] = key;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      list[i] <= list_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (append) begin
        count <= count + 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            key  <= head.key;
            mvec <= mvec_next;
            idx  <= '0;
            unique case (head.op)
              lot_pkg::OP_DUMP: state <= S_DUMP;
              default:          state <= S_SHIFT;
            endcase
          end
        end
        S_SHIFT: begin
          state <= S_IDLE;
        end
        S_DUMP: begin
          if (out_free) begin
            out_valid <= 1'b1;
            if (count == '0) begin
              out_item.entry_key   <= '0;
              out_item.entry_valid <= 1'b0;
              out_item.last        <= 1'b1;
              state                <= S_IDLE;
            end else begin
              out_item.entry_key   <= list[0];
              out_item.entry_valid <= 1'b1;
              out_item.last        <= dump_last;
              idx                  <= idx + 1'b1;
              if (dump_last) begin
                state <= S_IDLE;
              end
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/lru_order_tracker_unit.sv
// lru order tracker, top level; uses lot_pkg, lot_front, lot_cmd_fifo, lot_back
// and the assertion macros in lru_order_tracker_unit_defines.svh.
// Holds up to MAX_ENTRIES distinct key bytes in recency order. An access item
// moves a hit key to the most recent end, or appends a missed key, evicting
// the least recent one once capacity keys are held; it produces no result.
// A dump item returns every held key least recent first with last on the
// final one, or a single result with entry_valid low for an empty store.
// Items pass a one-item input stage and a two-item queue before execution.
// In the back stage an access first matches the key against all cells at
// once, then shifts the cells. A dump returns the held keys, at least one
// result, through the output register, which takes one key per cycle while
// the output does not stall, as the cells rotate.
// The capacity register is written through cfg and takes effect at once.
`include "lru_order_tracker_unit_defines.svh"

module lru_order_tracker_unit #(
  parameter int MAX_ENTRIES = lot_pkg::MAX_ENTRIES_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  lot_pkg::lot_in_t          in_item,
  output logic                      out_valid,
  input  logic                      out_ready,
  output lot_pkg::lot_out_t         out_item,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [lot_pkg::CAP_W-1:0] cfg_data
);

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  logic [lot_pkg::CAP_W-1:0] capacity;
  lot_pkg::lot_q_stat_t      q_stat;
  lot_pkg::lot_cmd_t         push_cmd;
  lot_pkg::lot_cmd_t         head;
  logic                      push;
  logic                      pop;
  logic [CNT_W-1:0]          count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= lot_pkg::CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity <= cfg_data;
    end
  end

  lot_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_stat   (q_stat),
    .push     (push),
    .push_cmd (push_cmd)
  );

  lot_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  lot_back #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .CNT_W       (CNT_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .capacity  (capacity),
    .q_stat    (q_stat),
    .head      (head),
    .pop       (pop),
    .count     (count),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  `LOT_ASSERT_NOW(a_count_bound, 1'b1, count <= CNT_W'(MAX_ENTRIES), "occupied count over depth")
  `LOT_ASSERT_NOW(a_no_overflow, push, !q_stat.full, "push into a full queue")
  `LOT_ASSERT_NOW(a_no_underflow, pop, !q_stat.empty, "pop from an empty queue")
  `LOT_ASSERT_NOW(a_empty_last, out_valid && !out_item.entry_valid, out_item.last, "empty result not last")
  `LOT_ASSERT_NEXT(a_count_step, count != CNT_W'(MAX_ENTRIES), count <= $past(count) + 1'b1, "count jumped")

endmodule
